@@ src/deq_pkg.sv @@
// Package for the double-ended queue: operation and status codes, word type,
// and the structs passed between the top level and the storage cells.
// Depends on nothing; every other file imports it.
package deq_pkg;

	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		OP_PUSH_RIGHT = 3'd0,
		OP_PUSH_LEFT  = 3'd1,
		OP_POP_RIGHT  = 3'd2,
		OP_POP_LEFT   = 3'd3,
		OP_PEEK_RIGHT = 3'd4,
		OP_PEEK_LEFT  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell in the same cycle.
	typedef struct packed {
		logic shift_r;  // push left: every word moves one cell to the right
		logic shift_l;  // pop left: every word moves one cell to the left
		logic push_r;   // first empty cell takes the new word
		logic pop_r;    // rightmost occupied cell empties itself
		logic fetch_r;  // rightmost occupied cell launches its word down the carry chain
	} cell_cmd_t;

	// Contents of one cell as seen by its neighbours.
	typedef struct packed {
		logic  valid;
		word_t word;
	} cell_state_t;

	// One stage of the carry chain that returns the right-end word to cell 0.
	typedef struct packed {
		logic  vld;
		word_t word;
	} carry_t;

endpackage

@@ src/deq_cell.sv @@
// One storage cell of the double-ended queue chain.
// Holds one word with its occupancy bit and one stage of the carry chain.
// Depends on deq_pkg.
module deq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  deq_pkg::cell_cmd_t  cmd,
	input  deq_pkg::word_t      value,
	input  deq_pkg::cell_state_t left,
	input  deq_pkg::cell_state_t right,
	input  deq_pkg::carry_t     right_carry,
	output deq_pkg::cell_state_t own,
	output deq_pkg::carry_t     carry
);
	import deq_pkg::*;

	logic  valid_q;
	word_t word_q;
	logic  carry_vld_q;
	word_t carry_word_q;
	logic  rightmost;
	logic  push_here;
	logic  deposit;

	// The occupied cells are always contiguous from cell 0, so both ends are
	// found from the neighbours alone.
	assign rightmost = valid_q && !right.valid;
	assign push_here = !valid_q && left.valid;
	assign deposit   = cmd.fetch_r && rightmost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			carry_vld_q <= 1'b0;
		end else begin
			if (cmd.shift_r) begin
				valid_q <= left.valid;
			end else if (cmd.shift_l) begin
				valid_q <= right.valid;
			end else if (cmd.push_r && push_here) begin
				valid_q <= 1'b1;
			end else if (cmd.pop_r && rightmost) begin
				valid_q <= 1'b0;
			end
			carry_vld_q <= deposit || right_carry.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_r) begin
			word_q <= left.word;
		end else if (cmd.shift_l) begin
			word_q <= right.word;
		end else if (cmd.push_r && push_here) begin
			word_q <= value;
		end
		carry_word_q <= deposit ? word_q : right_carry.word;
	end

	assign own   = '{valid: valid_q, word: word_q};
	assign carry = '{vld: carry_vld_q, word: carry_word_q};

endmodule

@@ src/double_ended_queue.sv @@
// Top level of the double-ended queue: command decode, result registers and
// the chain of storage cells.
// Depends on deq_pkg and deq_cell.
//
// A bounded double-ended queue of signed 32-bit words held in a row of DEPTH
// identical cells. The left end of the queue always sits in cell 0 and the
// words fill the cells contiguously towards the right. A request is taken at
// a rising edge where start is high and busy is low; every request produces
// exactly one result, shown on result_value and status for a single cycle
// while done is high. The receiver cannot hold results off, so it must take
// each one in the cycle in which done is high. Pushes at either end, pops and
// peeks at the left end, refused pushes (queue full), pops or peeks of an
// empty queue, and the unused operation codes all give their result in the
// cycle after the request is taken, and the next request may be taken in
// that same cycle. A pop or peek at the right end gives its result only once
// the rightmost word has been handed from cell to cell, one cell per cycle,
// along a carry chain that runs down to cell 0; busy stays high until then.
// A push while full leaves the queue unchanged and reports status full with
// a zero word; a pop or peek while empty reports status empty with a zero
// word.
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  deq_pkg::op_t      op,
	input  deq_pkg::word_t    value,
	output logic              done,
	output deq_pkg::word_t    result_value,
	output deq_pkg::status_t  status
);
	import deq_pkg::*;

	cell_cmd_t   cmd;
	cell_state_t cells     [DEPTH];
	cell_state_t left_in   [DEPTH];
	cell_state_t right_in  [DEPTH];
	carry_t      carries   [DEPTH];
	carry_t      rcarry_in [DEPTH];

	logic    accept;
	logic    empty;
	logic    full;
	logic    busy_q;
	logic    done_q;
	word_t   result_q;
	status_t status_q;

	// Decoded outcome of the request taken this cycle, when it completes at once.
	logic    finish_now;
	logic    wait_carry;
	word_t   res_word;
	status_t res_status;

	assign accept = start && !busy_q;

	// Occupancy is contiguous from cell 0, so the end cells tell the fill state.
	assign empty = !cells[0].valid;
	assign full  = cells[DEPTH-1].valid;

	always_comb begin
		cmd        = '0;
		finish_now = 1'b0;
		wait_carry = 1'b0;
		res_word   = '0;
		res_status = ST_OK;
		if (accept) begin
			finish_now = 1'b1;
			case (op)
				OP_PUSH_RIGHT, OP_PUSH_LEFT: begin
					if (full) begin
						res_status = ST_FULL;
					end else if (op == OP_PUSH_RIGHT) begin
						cmd.push_r = 1'b1;
					end else begin
						cmd.shift_r = 1'b1;
					end
				end
				OP_POP_LEFT, OP_PEEK_LEFT: begin
					if (empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_word    = cells[0].word;
						cmd.shift_l = (op == OP_POP_LEFT);
					end
				end
				OP_POP_RIGHT, OP_PEEK_RIGHT: begin
					if (empty) begin
						res_status = ST_EMPTY;
					end else begin
						// The rightmost cell launches its word; the result is
						// delivered when it reaches cell 0.
						finish_now  = 1'b0;
						wait_carry  = 1'b1;
						cmd.fetch_r = 1'b1;
						cmd.pop_r   = (op == OP_POP_RIGHT);
					end
				end
				default: begin
					// Unused codes do nothing and report ok with a zero word.
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (wait_carry) begin
				busy_q <= 1'b1;
			end else if (busy_q && carries[0].vld) begin
				busy_q <= 1'b0;
			end
			done_q <= finish_now || (busy_q && carries[0].vld);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && carries[0].vld) begin
			result_q <= carries[0].word;
			status_q <= ST_OK;
		end else if (finish_now) begin
			result_q <= res_word;
			status_q <= res_status;
		end
	end

	// Row of cells. Cell 0 sees an always-occupied left neighbour carrying the
	// incoming word, so a push at the left end is an ordinary shift to the
	// right. The last cell sees an empty right neighbour.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_in[i] = '{valid: 1'b1, word: value};
		end else begin : g_inner_l
			assign left_in[i] = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_in[i]  = '0;
			assign rcarry_in[i] = '0;
		end else begin : g_inner_r
			assign right_in[i]  = cells[i+1];
			assign rcarry_in[i] = carries[i+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.value       (value),
			.left        (left_in[i]),
			.right       (right_in[i]),
			.right_carry (rcarry_in[i]),
			.own         (cells[i]),
			.carry       (carries[i])
		);
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;

endmodule

@@ sim/double_ended_queue_tb.sv @@
// Self-checking testbench for double_ended_queue: a driver, a monitor and an
// in-bench ring-store predictor of the expected word and status per request.
// Depends on deq_pkg and the double_ended_queue RTL; needs no other file.
`timescale 1ns / 1ps

module double_ended_queue_tb;

	import deq_pkg::*;

	localparam int DEPTH = 16;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int RANDOM_REQUESTS = 1600;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 10;

	// Operation codes that the package leaves unnamed; the block treats them as no-ops.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// Biases for the random segments of the request stream.
	localparam int MIX_FILL     = 0;
	localparam int MIX_DRAIN    = 1;
	localparam int MIX_BALANCED = 2;

	typedef struct {
		op_t         code;
		word_t       word;
		int unsigned gap;
	} deque_request_t;

	typedef struct {
		word_t   word;
		status_t st;
	} deque_outcome_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	op_t     op = OP_PUSH_RIGHT;
	word_t   value = '0;
	logic    done;
	word_t   result_value;
	status_t status;

	// Requests waiting to be driven, and outcomes waiting to be seen.
	deque_request_t request_queue[$];
	deque_outcome_t awaited_outcomes[$];

	// The predictor's own copy of the deque: a ring store with two end
	// pointers and a fill count. The pointers wrap modulo DEPTH by width.
	word_t             mirror_slot[DEPTH];
	logic [PTR_W-1:0]  mirror_right = '0;
	logic [PTR_W-1:0]  mirror_left = '0;
	int unsigned       mirror_fill = 0;

	int unsigned idle_left = 0;
	int unsigned mismatch_count = 0;
	bit          quiet_stretch = 1'b0;

	double_ended_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.value(value),
		.done(done),
		.result_value(result_value),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Applies one request to the mirror and returns what the block should
	// report. A push while full and a pop or peek while empty leave the
	// mirror untouched; unused codes do nothing and report ok with zero.
	function automatic deque_outcome_t apply_operation(op_t code, word_t word);
		deque_outcome_t   outcome;
		logic [PTR_W-1:0] pos;
		outcome.word = '0;
		outcome.st = ST_OK;
		case (code)
			OP_PUSH_RIGHT, OP_PUSH_LEFT: begin
				if (mirror_fill >= DEPTH) begin
					outcome.st = ST_FULL;
				end else if (code == OP_PUSH_RIGHT) begin
					mirror_slot[mirror_right] = word;
					mirror_right = mirror_right + 1'b1;
					mirror_fill++;
				end else begin
					mirror_left = mirror_left - 1'b1;
					mirror_slot[mirror_left] = word;
					mirror_fill++;
				end
			end
			OP_POP_RIGHT, OP_POP_LEFT, OP_PEEK_RIGHT, OP_PEEK_LEFT: begin
				if (mirror_fill == 0) begin
					outcome.st = ST_EMPTY;
				end else begin
					// The right pointer sits one past the rightmost word.
					if (code == OP_POP_RIGHT || code == OP_PEEK_RIGHT)
						pos = mirror_right - 1'b1;
					else
						pos = mirror_left;
					outcome.word = mirror_slot[pos];
					if (code == OP_POP_RIGHT) begin
						mirror_right = pos;
						mirror_fill--;
					end else if (code == OP_POP_LEFT) begin
						mirror_left = mirror_left + 1'b1;
						mirror_fill--;
					end
				end
			end
			default: begin
			end
		endcase
		return outcome;
	endfunction

	// Idle cycles after a request: mostly none or a few, now and then a long
	// pause, and none at all during a quiet stretch.
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_stretch || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Random word, with the extremes and the small values over-represented.
	function automatic word_t draw_word();
		int unsigned r;
		r = $urandom_range(0, 11);
		case (r)
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return word_t'($urandom());
		endcase
	endfunction

	function automatic op_t pick_code(int mix);
		int unsigned r;
		int unsigned push_lim;
		int unsigned pop_lim;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				push_lim = 72;
				pop_lim = 86;
			end
			MIX_DRAIN: begin
				push_lim = 22;
				pop_lim = 80;
			end
			default: begin
				push_lim = 48;
				pop_lim = 76;
			end
		endcase
		// A few percent of unused codes act as noise in every segment.
		if (r < 2)
			return op_t'(OP_SPARE_6);
		else if (r < 4)
			return op_t'(OP_SPARE_7);
		else if (r < push_lim)
			return $urandom_range(0, 1) ? OP_PUSH_RIGHT : OP_PUSH_LEFT;
		else if (r < pop_lim)
			return $urandom_range(0, 1) ? OP_POP_RIGHT : OP_POP_LEFT;
		else
			return $urandom_range(0, 1) ? OP_PEEK_RIGHT : OP_PEEK_LEFT;
	endfunction

	task automatic queue_request(op_t code, word_t word);
		deque_request_t req;
		req.code = code;
		req.word = word;
		req.gap = draw_gap();
		request_queue.push_back(req);
	endtask

	task automatic note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Driver. A request counts as taken at an edge where start is high and
	// busy is low; its outcome is predicted there and then. Start is only
	// changed when the current request has gone or none is being offered,
	// and it gets at most one assignment per edge, so a request that follows
	// straight on keeps start high without a glitch.
	always @(posedge clk) begin
		deque_request_t req;
		if (arst_n) begin
			if (start && !busy)
				awaited_outcomes.push_back(apply_operation(op, value));
			if (!start || !busy) begin
				if (idle_left > 0) begin
					start <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (request_queue.size() != 0) begin
					req = request_queue.pop_front();
					start <= 1'b1;
					op <= req.code;
					value <= req.word;
					idle_left <= req.gap;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. Done marks a result for one cycle only, so it is sampled at
	// every edge and compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		deque_outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_outcomes.size() == 0) begin
				note_mismatch($sformatf("result %0d status %0d with no request outstanding",
					result_value, status));
			end else begin
				want = awaited_outcomes.pop_front();
				if (result_value !== want.word || status !== want.st)
					note_mismatch($sformatf("expected value %0d status %s, got value %0d status %0d",
						want.word, want.st.name(), result_value, status));
			end
		end
	end

	// Watchdog: a correct run needs a small fraction of this.
	initial begin
		for (int c = 0; c < CYCLE_LIMIT; c++)
			@(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned random_count;
		int unsigned seg_len;
		int          mix;

		// Directed part. First every read of an empty queue and a spare code.
		queue_request(OP_POP_RIGHT, word_t'($urandom()));
		queue_request(OP_POP_LEFT, word_t'($urandom()));
		queue_request(OP_PEEK_RIGHT, word_t'($urandom()));
		queue_request(OP_PEEK_LEFT, word_t'($urandom()));
		queue_request(op_t'(OP_SPARE_6), word_t'($urandom()));
		// Removing the last word from either end must leave a sane empty queue.
		queue_request(OP_PUSH_RIGHT, 32'sh7FFF_FFFF);
		queue_request(OP_POP_LEFT, '0);
		queue_request(OP_PUSH_LEFT, 32'sh8000_0000);
		queue_request(OP_POP_RIGHT, '0);
		// Fill to the brim from both ends, with the extreme words among them,
		// then try a push at each end while full.
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0: queue_request(OP_PUSH_RIGHT, 32'sh7FFF_FFFF);
				1: queue_request(OP_PUSH_LEFT, 32'sh8000_0000);
				2: queue_request(OP_PUSH_RIGHT, -32'sd1);
				3: queue_request(OP_PUSH_LEFT, 32'sd0);
				default: queue_request(i[0] ? OP_PUSH_LEFT : OP_PUSH_RIGHT,
					word_t'($urandom()));
			endcase
		end
		queue_request(OP_PUSH_RIGHT, word_t'($urandom()));
		queue_request(OP_PUSH_LEFT, word_t'($urandom()));
		queue_request(OP_PEEK_RIGHT, '0);
		queue_request(OP_PEEK_LEFT, '0);
		// The slowest request: a right pop with the queue full.
		queue_request(OP_POP_RIGHT, '0);

		// Random part, in segments that lean towards filling, draining or
		// neither, so that both the full and the empty ends are reached
		// often and the pointers wrap many times round the ring.
		random_count = 0;
		while (random_count < RANDOM_REQUESTS) begin
			seg_len = $urandom_range(10, 60);
			mix = $urandom_range(MIX_FILL, MIX_BALANCED);
			quiet_stretch = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < seg_len; i++)
				queue_request(pick_code(mix), draw_word());
			random_count += seg_len;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// All requests taken, then every result seen, then a settling pause
		// longer than the slowest right-end fetch in case a stray result follows.
		while (request_queue.size() != 0 || start)
			@(posedge clk);
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		if (mismatch_count == 0 && awaited_outcomes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ double_ended_queue.f @@
src/deq_pkg.sv
src/deq_cell.sv
src/double_ended_queue.sv
sim/double_ended_queue_tb.sv
